// ===== hw/rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and defaults for the linear-probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  // default geometry
  localparam int DEF_SLOTS    = 64;
  localparam int DEF_KEY_BITS = 31;
  // capacity register value after reset, clamped to SLOTS
  localparam int CAP_RESET    = 64;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } kind_t;

endpackage

// ===== hw/rtl/linear_probe_hash_set_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// Set of keys in an open-addressed table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// A request is accepted, then the bit-serial remainder unit finds its home
// slot (key mod capacity), then slots are probed in turn from home, up to
// capacity probes, and the reply is posted; the reply waits only while an
// earlier reply is still held on the output. An insert into a full table
// skips the remainder unit and the probe and goes straight to the reply. A
// clear sweeps every one of the SLOTS memory rows, one a cycle. After reset
// the same sweep runs and no request is accepted meanwhile; capacity writes
// are taken at any time. The slot memory has one read and one write port;
// probing issues one read per cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_unit
  import lphs_pkg::*;
#(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int SLOT_BITS = $clog2(SLOTS),
  localparam int CAP_BITS  = $clog2(SLOTS + 1),
  localparam int KEY_W     = ((KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((1 + SLOT_BITS + CAP_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CAP_BITS-1:0] cfg_wdata,   // capacity
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [KEY_W-1:0]    s_tdata,     // key
  input  logic [1:0]          s_tuser,     // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata      // ok, slot, entries
);

  localparam int WORD_BITS = KEY_BITS + 2;
  localparam int CAP_INIT  = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;
  localparam int AW1       = SLOT_BITS + 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t               state;
  logic [CAP_BITS-1:0]  cap;
  logic [CAP_BITS-1:0]  count;
  kind_t                kind;
  logic [KEY_BITS-1:0]  key;
  logic [SLOT_BITS-1:0] addr;
  logic [CAP_BITS-1:0]  probe_cnt;
  logic                 free_found;
  logic [SLOT_BITS-1:0] free_slot;
  logic [SLOT_BITS-1:0] clr_addr;
  logic                 clr_reply;
  logic                 res_ok;
  logic [SLOT_BITS-1:0] res_slot;

  logic                 accept;
  kind_t                in_kind;
  logic [KEY_BITS-1:0]  in_key;
  logic                 in_full;
  logic                 mod_start;
  logic                 mod_done;
  logic [SLOT_BITS-1:0] mod_rem;

  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [WORD_BITS-1:0] wr_word;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [WORD_BITS-1:0] rd_word;

  logic                 rd_used;
  logic                 rd_occ;
  logic [KEY_BITS-1:0]  rd_key;
  logic                 hit;
  logic                 last;
  logic                 stop;
  logic                 cand_ok;
  logic [SLOT_BITS-1:0] cand;
  logic [AW1-1:0]       addr_p1;
  logic [SLOT_BITS-1:0] addr_wrap;
  logic                 probe_ok;
  logic [SLOT_BITS-1:0] probe_slot;
  logic [CAP_BITS-1:0]  count_next;
  logic [CAP_BITS-1:0]  cap_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_kind  = kind_t'(s_tuser);
  assign in_key   = s_tdata[KEY_BITS-1:0];
  assign in_full  = (count >= cap);

  assign mod_start = accept && (in_kind != OP_CLEAR) &&
                     !((in_kind == OP_INSERT) && in_full);

  // clamp capacity into 1..SLOTS on write
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_next = CAP_BITS'(1);
    end else if (cfg_wdata > CAP_BITS'(SLOTS)) begin
      cap_next = CAP_BITS'(SLOTS);
    end else begin
      cap_next = cfg_wdata;
    end
  end

  lphs_mod_unit #(
    .KEY_BITS  (KEY_BITS),
    .CAP_BITS  (CAP_BITS),
    .SLOT_BITS (SLOT_BITS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (in_key),
    .cap   (cap),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lphs_table #(
    .DEPTH     (SLOTS),
    .ADDR_BITS (SLOT_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // word layout: {used, occupied, key}
  assign rd_used = rd_word[KEY_BITS+1];
  assign rd_occ  = rd_word[KEY_BITS];
  assign rd_key  = rd_word[KEY_BITS-1:0];

  assign addr_p1   = {1'b0, addr} + 1'b1;
  assign addr_wrap = (addr_p1 >= AW1'(cap)) ? '0 : addr_p1[SLOT_BITS-1:0];

  assign hit     = rd_occ && (rd_key == key);
  assign last    = ((probe_cnt + 1'b1) == cap);
  assign stop    = hit || !rd_used || last;
  // first unoccupied slot seen from home, tombstone or empty
  assign cand_ok = free_found || !rd_occ;
  assign cand    = free_found ? free_slot : addr;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = addr;
    wr_word    = '0;
    probe_ok   = 1'b0;
    probe_slot = '0;
    count_next = count;
    // read the slot that the next probe cycle examines
    rd_addr    = (state == ST_MOD) ? mod_rem : addr_wrap;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (state == ST_PROBE && stop) begin
      case (kind)
        OP_SEARCH: begin
          probe_ok   = hit;
          probe_slot = hit ? addr : '0;
        end
        OP_REMOVE: begin
          if (hit) begin
            probe_ok   = 1'b1;
            probe_slot = addr;
            wr_en      = 1'b1;
            wr_word    = {1'b1, 1'b0, rd_key};
            if (count != '0) begin
              count_next = count - 1'b1;
            end
          end
        end
        OP_INSERT: begin
          if (!hit && cand_ok) begin
            probe_ok   = 1'b1;
            probe_slot = cand;
            wr_en      = 1'b1;
            wr_addr    = cand;
            wr_word    = {1'b1, 1'b1, key};
            count_next = count + 1'b1;
          end
        end
        default: begin
          probe_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      count     <= '0;
      cap       <= CAP_BITS'(CAP_INIT);
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cap <= cap_next;
      end
      // drop a taken reply unless the next one is loaded below
      if (m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_BITS'(SLOTS - 1)) begin
            clr_addr <= '0;
            if (clr_reply) begin
              res_ok   <= 1'b1;
              res_slot <= '0;
              state    <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind <= in_kind;
            key  <= in_key;
            if (in_kind == OP_CLEAR) begin
              count     <= '0;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= ST_CLEAR;
            end else if (in_kind == OP_INSERT && in_full) begin
              res_ok   <= 1'b0;
              res_slot <= '0;
              state    <= ST_DONE;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            addr       <= mod_rem;
            probe_cnt  <= '0;
            free_found <= 1'b0;
            state      <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (stop) begin
            res_ok   <= probe_ok;
            res_slot <= probe_slot;
            count    <= count_next;
            state    <= ST_DONE;
          end else begin
            if (!free_found && !rd_occ) begin
              free_found <= 1'b1;
              free_slot  <= addr;
            end
            addr      <= addr_wrap;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          // hold the reply until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({count, res_slot, res_ok});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lphs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// lphs_mod_unit
// Bit-serial remainder unit: key mod capacity, one key bit per cycle.
// ----------------------------------------------------------------------------
module lphs_mod_unit #(
  parameter int KEY_BITS  = 31,
  parameter int CAP_BITS  = 7,
  parameter int SLOT_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [CAP_BITS-1:0]  cap,
  output logic                 done,
  output logic [SLOT_BITS-1:0] rem
);

  localparam int CNT_BITS = $clog2(KEY_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [KEY_BITS-1:0] shreg;
  logic [CAP_BITS-1:0] acc;
  logic [CAP_BITS:0]   trial;
  logic [CAP_BITS:0]   diff;
  logic [CAP_BITS-1:0] acc_next;

  // one restoring step: shift in the next key bit, subtract when it fits
  always_comb begin
    trial = {acc, shreg[KEY_BITS-1]};
    diff  = trial - {1'b0, cap};
    if (trial >= {1'b0, cap}) begin
      acc_next = diff[CAP_BITS-1:0];
    end else begin
      acc_next = trial[CAP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(KEY_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= key;
      acc   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KEY_BITS-2:0], 1'b0};
      acc   <= acc_next;
    end
  end

  // remainder is below capacity, so it fits a slot index
  assign rem = acc[SLOT_BITS-1:0];

endmodule

// ===== hw/rtl/lphs_table.sv =====
// ----------------------------------------------------------------------------
// lphs_table
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lphs_table #(
  parameter int DEPTH      = 64,
  parameter int ADDR_BITS  = 6,
  parameter int WORD_BITS  = 33
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
